### src/md5sh_pkg.sv
package md5sh_pkg;

   // datapath commands, one group per cycle from the controller
   typedef struct packed {
      logic       load_byte;
      logic       pad;
      logic       clear_block;
      logic       write_len;
      logic       start_round;
      logic       round_a;
      logic       round_b;
      logic       chain_add;
      logic       reinit;
      logic [5:0] round;
      logic [1:0] word_sel;
   } md5sh_cmd_type;

   // datapath status back to the controller
   typedef struct packed {
      logic [5:0] fill;
   } md5sh_status_type;

   localparam logic [31:0] CHAIN_INIT [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] ROUND_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotate amounts, indexed by {round group, round mod 4}
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] FILL_FULL  = 6'h3f;
   localparam logic [5:0] PAD_LIMIT  = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [1:0] LAST_WORD  = 2'd3;

endpackage

### src/md5sh_req_if.sv
interface md5sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

### src/md5sh_rsp_if.sv
interface md5sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_number;
   logic        last_word;

   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

### src/md5sh_datapath.sv
module md5sh_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  md5sh_pkg::md5sh_cmd_type    cmd,
   input  logic [7:0]                  data_byte,
   output md5sh_pkg::md5sh_status_type status,
   output logic [31:0]                 digest
);
   import md5sh_pkg::*;

   logic [31:0] chain_ff [4];
   logic [31:0] block_ff [16];
   logic [63:0] total_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] sum_ff;

   logic [1:0]  grp;
   logic [3:0]  idx;
   logic [31:0] f_val;
   logic [3:0]  g_idx;
   logic [4:0]  rot_s;
   logic [63:0] rot_wide;
   logic [5:0]  fill;
   logic [3:0]  fill_w;
   logic [1:0]  fill_b;

   // merge one byte into a word; the first byte of a word clears the rest
   function automatic logic [31:0] place_byte(input logic [31:0] word,
                                              input logic [7:0]  val,
                                              input logic [1:0]  sh);
      logic [31:0] res;
      case (sh)
         2'd0:    res = {24'b0, val};
         2'd1:    res = word | {16'b0, val, 8'b0};
         2'd2:    res = word | {8'b0, val, 16'b0};
         2'd3:    res = word | {val, 24'b0};
         default: res = word;
      endcase
      return res;
   endfunction

   assign fill   = total_ff[5:0];
   assign fill_w = fill[5:2];
   assign fill_b = fill[1:0];

   assign status.fill = fill;
   assign digest      = chain_ff[cmd.word_sel];

   // round function and message word select
   assign grp = cmd.round[5:4];
   assign idx = cmd.round[3:0];

   always_comb begin
      case (grp)
         2'd0: begin
            f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
            g_idx = idx;
         end
         2'd1: begin
            f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
            g_idx = 4'(4'd5 * idx + 4'd1);
         end
         2'd2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            g_idx = 4'(4'd3 * idx + 4'd5);
         end
         default: begin
            f_val = c_ff ^ (b_ff | ~d_ff);
            g_idx = 4'(4'd7 * idx);
         end
      endcase
   end

   // left rotate of the round sum
   assign rot_s    = ROT_AMOUNT[{grp, cmd.round[1:0]}];
   assign rot_wide = {sum_ff, sum_ff} << rot_s;

   // chaining words and byte count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= CHAIN_INIT[k];
         end
         total_ff <= '0;
      end else begin
         if (cmd.load_byte) begin
            total_ff <= total_ff + 64'd1;
         end
         if (cmd.chain_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.reinit) begin
            for (int k = 0; k < 4; k++) begin
               chain_ff[k] <= CHAIN_INIT[k];
            end
            total_ff <= '0;
         end
      end
   end

   // message block words
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         block_ff[fill_w] <= place_byte(block_ff[fill_w], data_byte, fill_b);
      end
      if (cmd.pad) begin
         for (int j = 0; j < 16; j++) begin
            if (4'(j) == fill_w) begin
               block_ff[j] <= place_byte(block_ff[j], PAD_BYTE, fill_b);
            end else if (5'(j) > {1'b0, fill_w}) begin
               block_ff[j] <= '0;
            end
         end
      end
      if (cmd.clear_block) begin
         for (int j = 0; j < 16; j++) begin
            block_ff[j] <= '0;
         end
      end
      if (cmd.write_len) begin
         block_ff[14] <= {total_ff[28:0], 3'b000};
         block_ff[15] <= total_ff[60:29];
      end
   end

   // working variables; each round is a sum step followed by a rotate-and-shift step
   always_ff @(posedge clock) begin
      if (cmd.start_round) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end
      if (cmd.round_a) begin
         sum_ff <= a_ff + f_val + ROUND_ADD[cmd.round] + block_ff[g_idx];
      end
      if (cmd.round_b) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_ff + rot_wide[63:32];
      end
   end

endmodule

### src/md5sh_ctrl.sv
module md5sh_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_has_byte,
   input  logic                        req_end,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_word,
   output logic                        rsp_last,
   input  md5sh_pkg::md5sh_status_type status,
   output md5sh_pkg::md5sh_cmd_type    cmd
);
   import md5sh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_CLEAR,
      S_LENGTH,
      S_ROUND_A,
      S_ROUND_B,
      S_CHAIN,
      S_EMIT
   } state_type;

   state_type  state_ff;
   state_type  resume_ff;
   logic [5:0] round_ff;
   logic [1:0] word_ff;
   logic       rsp_valid_ff;
   logic       block_full;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = word_ff;
   assign rsp_last   = (word_ff == LAST_WORD);
   assign block_full = req_has_byte && (status.fill == FILL_FULL);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resume_ff    <= S_IDLE;
         round_ff     <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (block_full) begin
                     state_ff  <= S_ROUND_A;
                     round_ff  <= '0;
                     resume_ff <= req_end ? S_PAD : S_IDLE;
                  end else if (req_end) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               if (status.fill >= PAD_LIMIT) begin
                  state_ff  <= S_ROUND_A;
                  round_ff  <= '0;
                  resume_ff <= S_CLEAR;
               end else begin
                  state_ff <= S_LENGTH;
               end
            end
            S_CLEAR: begin
               state_ff <= S_LENGTH;
            end
            S_LENGTH: begin
               state_ff  <= S_ROUND_A;
               round_ff  <= '0;
               resume_ff <= S_EMIT;
            end
            S_ROUND_A: begin
               state_ff <= S_ROUND_B;
            end
            S_ROUND_B: begin
               if (round_ff == LAST_ROUND) begin
                  state_ff <= S_CHAIN;
               end else begin
                  round_ff <= round_ff + 6'd1;
                  state_ff <= S_ROUND_A;
               end
            end
            S_CHAIN: begin
               state_ff <= resume_ff;
               if (resume_ff == S_EMIT) begin
                  rsp_valid_ff <= 1'b1;
                  word_ff      <= '0;
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  if (word_ff == LAST_WORD) begin
                     rsp_valid_ff <= 1'b0;
                     state_ff     <= S_IDLE;
                  end else begin
                     word_ff <= word_ff + 2'd1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.round    = round_ff;
      cmd.word_sel = word_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load_byte   = req_valid && req_has_byte;
            cmd.start_round = req_valid && block_full;
         end
         S_PAD: begin
            cmd.pad         = 1'b1;
            cmd.start_round = (status.fill >= PAD_LIMIT);
         end
         S_CLEAR: begin
            cmd.clear_block = 1'b1;
         end
         S_LENGTH: begin
            cmd.write_len   = 1'b1;
            cmd.start_round = 1'b1;
         end
         S_ROUND_A: begin
            cmd.round_a = 1'b1;
         end
         S_ROUND_B: begin
            cmd.round_b = 1'b1;
         end
         S_CHAIN: begin
            cmd.chain_add = 1'b1;
         end
         S_EMIT: begin
            cmd.reinit = rsp_ready && (word_ff == LAST_WORD);
         end
         default: begin
            cmd.round = round_ff;
         end
      endcase
   end

   // the input side and the digest output are never open together
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid_ff))
      else $error("input accepted while digest pending");

   // chain update follows the last round only
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHAIN) |-> ($past(state_ff) == S_ROUND_B && $past(round_ff) == LAST_ROUND))
      else $error("chain update before round 63");

   // digest always starts at word A
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (word_ff == 2'd0))
      else $error("digest does not start at word A");

   // after the D word the block is back to accepting bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && word_ff == LAST_WORD) |=>
         (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("no return to idle after last digest word");

endmodule

### src/md5_stream_hasher_top.sv
// MD5 digest of a byte stream.
// req_chan: one item per transfer; has_byte adds data_byte to the message,
//   end_of_message closes the message after that byte (an item with no byte
//   and no end changes nothing).
// rsp_chan: four transfers per message, words A, B, C, D with word_number
//   0..3 and last_word on D. Digest bytes are taken low byte first.
// Throughput: one byte per cycle while a 64-byte block fills. Each full block
//   holds off input while the compression runs its 64 rounds, each a sum step
//   then a rotate step through one rotate unit, and then the chain add.
// From the end item to word A: pad, length write, compression; a block filled
//   by the end item is compressed first, and one more compression follows
//   when the pad and length need an extra block.
// When rsp_chan stalls, the digest words wait and no input is taken; after
//   the D word transfers the chaining state and byte count go back to their
//   initial values and input resumes the next cycle.
// Reset (synchronous): loads the initial chaining words, clears the byte
//   count and returns to accepting input; no clearing pass is needed.
module md5_stream_hasher_top (
   input logic         clock,
   input logic         reset,
   md5sh_req_if.sink   req_chan,
   md5sh_rsp_if.source rsp_chan
);
   import md5sh_pkg::*;

   md5sh_cmd_type    cmd;
   md5sh_status_type status;

   // sequencer
   md5sh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_has_byte (req_chan.has_byte),
      .req_end      (req_chan.end_of_message),
      .req_ready    (req_chan.ready),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_word     (rsp_chan.word_number),
      .rsp_last     (rsp_chan.last_word),
      .status       (status),
      .cmd          (cmd)
   );

   // block buffer, round unit and chaining state
   md5sh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_chan.data_byte),
      .status    (status),
      .digest    (rsp_chan.digest_word)
   );

endmodule
